/* rtl/mwf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants of the median window filter: controller states,
// command and status groups, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mwf_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int OCOL_W     = 11;
    localparam int HALF_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_W_W    = 12;
    localparam int MAX_ROWS   = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // register reset values
    localparam logic [HALF_W-1:0]  RST_HALF   = 3'd1;
    localparam logic [CFG_W_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [HGT_W-1:0]   RST_HEIGHT = 13'd480;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic scan;
        logic decide;
        logic next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic acc_have;
        logic scan_last;
        logic sel_done;
        logic res_last;
    } t_status;

endpackage

/* rtl/mwf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mwf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_ctrl
// Sequencer of the median filter: accepts a pixel, then for every finished
// window runs two radix selections over the line store and hands out a result.
// ----------------------------------------------------------------------------
module mwf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  mwf_pkg::t_status i_st,
    output mwf_pkg::t_cmd    o_cmd
);

    mwf_pkg::t_state r_state;
    mwf_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        case (r_state)
            mwf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.acc_have) begin
                        n_state = mwf_pkg::S_SETUP;
                    end
                end
            end
            mwf_pkg::S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = mwf_pkg::S_SCAN;
            end
            mwf_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_st.scan_last) begin
                    n_state = mwf_pkg::S_DRAIN;
                end
            end
            mwf_pkg::S_DRAIN: begin
                n_state = mwf_pkg::S_DECIDE;
            end
            mwf_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_st.sel_done ? mwf_pkg::S_OUT : mwf_pkg::S_SCAN;
            end
            mwf_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_st.res_last) begin
                        n_state = mwf_pkg::S_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = mwf_pkg::S_SETUP;
                    end
                end
            end
            default: begin
                n_state = mwf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mwf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwf_datapath
// Registers, raster counters, line store and the bit-by-bit median selection
// that counts window pixels below a candidate prefix.
// ----------------------------------------------------------------------------
module mwf_datapath #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HALF  = 7
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mwf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [mwf_pkg::PIX_W-1:0]        i_pixel_in,
    input  mwf_pkg::t_cmd                    i_cmd,
    output mwf_pkg::t_status                 o_st,
    output logic [mwf_pkg::ROW_W-1:0]        o_out_row,
    output logic [mwf_pkg::OCOL_W-1:0]       o_out_col,
    output logic [mwf_pkg::PIX_W-1:0]        o_median_value,
    output logic                             o_frame_done
);

    localparam int RING  = 2 * MAX_HALF + 1;
    localparam int SW    = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WW > mwf_pkg::CFG_W_W) ? WW : mwf_pkg::CFG_W_W;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]   LINE     = AW'(MAX_WIDTH);
    localparam logic [SW-1:0]   SLOT_MAX = SW'(RING - 1);
    localparam int HW = mwf_pkg::HALF_W;
    localparam int RW = mwf_pkg::ROW_W;
    localparam int GW = mwf_pkg::HGT_W;

    // configuration and latched frame settings
    logic [HW-1:0]               r_cfg_h;
    logic [mwf_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [GW-1:0]               r_cfg_hgt;
    logic [HW-1:0]               r_act_h;
    logic [WW-1:0]               r_act_w;
    logic [GW-1:0]               r_act_hgt;

    // raster position of the next pixel
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [SW-1:0] r_slot;

    // result iteration
    logic [RW-1:0] r_y, r_y1, r_cur_row;
    logic [CW-1:0] r_x, r_x0, r_x1;
    logic [SW-1:0] r_cur_slot;

    // window scan
    logic [RW-1:0] r_sr, r_sr0, r_r1;
    logic [CW-1:0] r_sc, r_c0, r_c1;
    logic [SW-1:0] r_sslot, r_sslot0;
    logic          r_rd_vld;

    // selection
    logic [7:0] r_k, r_k2, r_cnt, r_pref, r_v1, r_med;
    logic [2:0] r_b;
    logic       r_sel;

    // ------------------------------------------------------------------
    // effective sizes at this pixel
    logic          frame_start;
    logic [HW-1:0] h_clamp, eff_h;
    logic [CMPW-1:0] w_ext;
    logic [WW-1:0] w_clamp, eff_w;
    logic [GW-1:0] hgt_clamp, eff_hgt;

    always_comb begin
        frame_start = (r_row == '0) && (r_col == '0);
        h_clamp = (r_cfg_h > HW'(MAX_HALF)) ? HW'(MAX_HALF) : r_cfg_h;
        w_ext   = CMPW'(r_cfg_w);
        if (w_ext == '0) begin
            w_clamp = WW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(w_ext);
        end
        if (r_cfg_hgt == '0) begin
            hgt_clamp = GW'(1);
        end else if (r_cfg_hgt > GW'(mwf_pkg::MAX_ROWS)) begin
            hgt_clamp = GW'(mwf_pkg::MAX_ROWS);
        end else begin
            hgt_clamp = r_cfg_hgt;
        end
        eff_h   = frame_start ? h_clamp : r_act_h;
        eff_w   = frame_start ? w_clamp : r_act_w;
        eff_hgt = frame_start ? hgt_clamp : r_act_hgt;
    end

    // results completed by the incoming pixel
    logic          row_end, col_end, have_y, have_x;
    logic [RW-1:0] acc_y0, acc_y1;
    logic [CW-1:0] acc_x0, acc_x1;

    always_comb begin
        row_end = (GW'(r_row) + GW'(1)) >= eff_hgt;
        col_end = ((WW + 1)'(r_col) + (WW + 1)'(1)) >= (WW + 1)'(eff_w);
        have_y  = row_end || (r_row >= RW'(eff_h));
        have_x  = col_end || (r_col >= CW'(eff_h));
        acc_y0  = (r_row >= RW'(eff_h)) ? (r_row - RW'(eff_h)) : '0;
        acc_y1  = row_end ? r_row : acc_y0;
        acc_x0  = (r_col >= CW'(eff_h)) ? (r_col - CW'(eff_h)) : '0;
        acc_x1  = col_end ? r_col : acc_x0;
    end

    assign o_st.acc_have = have_y && have_x;

    // window of the current result
    logic [RW-1:0]   ry0, ry1;
    logic [GW-1:0]   ry_hi;
    logic [CW-1:0]   cx0, cx1;
    logic [WW:0]     cx_hi;
    logic [3:0]      nr, nc;
    logic [7:0]      n_win;
    logic [SW-1:0]   d_slot, slot0;

    always_comb begin
        ry0   = (r_y >= RW'(r_act_h)) ? (r_y - RW'(r_act_h)) : '0;
        ry_hi = GW'(r_y) + GW'(r_act_h);
        ry1   = (ry_hi < r_act_hgt) ? RW'(ry_hi) : RW'(r_act_hgt - GW'(1));
        cx0   = (r_x >= CW'(r_act_h)) ? (r_x - CW'(r_act_h)) : '0;
        cx_hi = (WW + 1)'(r_x) + (WW + 1)'(r_act_h);
        cx1   = (cx_hi < (WW + 1)'(r_act_w)) ? CW'(cx_hi) : CW'(r_act_w - WW'(1));
        nr    = 4'(ry1 - ry0) + 4'd1;
        nc    = 4'(cx1 - cx0) + 4'd1;
        n_win = 8'(nr) * 8'(nc);
        d_slot = SW'(r_cur_row - ry0);
        if (r_cur_slot >= d_slot) begin
            slot0 = r_cur_slot - d_slot;
        end else begin
            slot0 = SW'((SW + 1)'(r_cur_slot) + (SW + 1)'(RING) - (SW + 1)'(d_slot));
        end
    end

    // line store
    logic [AW-1:0]             waddr, raddr;
    logic [mwf_pkg::PIX_W-1:0] rdata;

    assign waddr = AW'(r_slot) * LINE + AW'(r_col);
    assign raddr = AW'(r_sslot) * LINE + AW'(r_sc);

    mwf_ram #(
        .WIDTH(mwf_pkg::PIX_W),
        .DEPTH(DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept),
        .i_waddr(waddr),
        .i_wdata(i_pixel_in),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // prefix match and selection decision
    logic [7:0] hi_mask, pref_new;
    logic       match, bit_one;

    always_comb begin
        hi_mask  = 8'hFE << r_b;
        match    = (((rdata ^ r_pref) & hi_mask) == 8'h00) && !rdata[r_b];
        bit_one  = r_k >= r_cnt;
        pref_new = r_pref | (bit_one ? (8'h01 << r_b) : 8'h00);
    end

    assign o_st.scan_last = (r_sr == r_r1) && (r_sc == r_c1);
    assign o_st.sel_done  = (r_b == 3'd0) && r_sel;
    assign o_st.res_last  = (r_y == r_y1) && (r_x == r_x1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_h   <= mwf_pkg::RST_HALF;
            r_cfg_w   <= mwf_pkg::RST_WIDTH;
            r_cfg_hgt <= mwf_pkg::RST_HEIGHT;
            r_act_h   <= mwf_pkg::RST_HALF;
            r_act_w   <= WW'(mwf_pkg::RST_WIDTH);
            r_act_hgt <= mwf_pkg::RST_HEIGHT;
            r_row     <= '0;
            r_col     <= '0;
            r_slot    <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mwf_pkg::CFG_HALF:   r_cfg_h   <= i_cfg_data[HW-1:0];
                    mwf_pkg::CFG_WIDTH:  r_cfg_w   <= i_cfg_data[mwf_pkg::CFG_W_W-1:0];
                    mwf_pkg::CFG_HEIGHT: r_cfg_hgt <= i_cfg_data;
                    default: ;
                endcase
            end
            // raster advance on a pixel transaction
            if (i_cmd.accept) begin
                r_act_h   <= eff_h;
                r_act_w   <= eff_w;
                r_act_hgt <= eff_hgt;
                if (col_end) begin
                    r_col <= '0;
                    if (row_end) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= (r_slot == SLOT_MAX) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // result iteration, scan and selection registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_y        <= acc_y0;
            r_y1       <= acc_y1;
            r_x        <= acc_x0;
            r_x0       <= acc_x0;
            r_x1       <= acc_x1;
            r_cur_row  <= r_row;
            r_cur_slot <= r_slot;
        end
        if (i_cmd.next) begin
            if (r_x == r_x1) begin
                r_x <= r_x0;
                r_y <= r_y + RW'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
        if (i_cmd.setup) begin
            r_sr     <= ry0;
            r_sr0    <= ry0;
            r_r1     <= ry1;
            r_sc     <= cx0;
            r_c0     <= cx0;
            r_c1     <= cx1;
            r_sslot  <= slot0;
            r_sslot0 <= slot0;
            r_k      <= (n_win - 8'd1) >> 1;
            r_k2     <= n_win >> 1;
            r_b      <= 3'd7;
            r_pref   <= 8'h00;
            r_sel    <= 1'b0;
            r_cnt    <= 8'h00;
        end
        // walk the window in raster order
        if (i_cmd.scan) begin
            if (r_sc == r_c1) begin
                r_sc    <= r_c0;
                r_sr    <= r_sr + RW'(1);
                r_sslot <= (r_sslot == SLOT_MAX) ? '0 : r_sslot + SW'(1);
            end else begin
                r_sc <= r_sc + CW'(1);
            end
        end
        // count pixels that match the prefix with a zero at the current bit
        if (r_rd_vld && match) begin
            r_cnt <= r_cnt + 8'd1;
        end
        // fix one bit of the selected value
        if (i_cmd.decide) begin
            r_cnt   <= 8'h00;
            r_sc    <= r_c0;
            r_sr    <= r_sr0;
            r_sslot <= r_sslot0;
            if ((r_b == 3'd0) && !r_sel) begin
                r_v1   <= pref_new;
                r_pref <= 8'h00;
                r_k    <= r_k2;
                r_b    <= 3'd7;
                r_sel  <= 1'b1;
            end else begin
                if (bit_one) begin
                    r_k <= r_k - r_cnt;
                end
                if (r_b == 3'd0) begin
                    r_med <= 8'((9'(r_v1) + 9'(pref_new)) >> 1);
                end else begin
                    r_pref <= pref_new;
                    r_b    <= r_b - 3'd1;
                end
            end
        end
    end

    // result fields
    assign o_out_row      = r_y;
    assign o_out_col      = mwf_pkg::OCOL_W'(r_x);
    assign o_median_value = r_med;
    assign o_frame_done   = ((GW'(r_y) + GW'(1)) == r_act_hgt)
                         && (((WW + 1)'(r_x) + (WW + 1)'(1)) == (WW + 1)'(r_act_w));

endmodule

/* rtl/median_window_filter.sv */
`timescale 1ns / 1ps
// Sequence: a pixel that completes no window is taken while idle; each result
// runs a setup step, then for every bit of two 8-bit radix selections a scan of
// the clipped window (up to 225 pixels, each read from the line store once), a
// drain step and a decide step, then an output step held while output stalls.
// Throughput: one item at a time; the next pixel is taken after its results go.
// Reset: synchronous active low; state, settings and raster counters return to
// reset values; line store, result, scan and selection registers are not cleared.
// ----------------------------------------------------------------------------
// median_window_filter
// Streaming 2D median filter over a clipped square window of 8-bit pixels.
// ----------------------------------------------------------------------------
module median_window_filter #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HALF  = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mwf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mwf_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mwf_pkg::ROW_W-1:0]      o_out_row,
    output logic [mwf_pkg::OCOL_W-1:0]     o_out_col,
    output logic [mwf_pkg::PIX_W-1:0]      o_median_value,
    output logic                           o_run_last,
    output logic                           o_frame_done
);

    mwf_pkg::t_cmd    cmd;
    mwf_pkg::t_status st;

    // sequencer
    mwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath
    mwf_datapath #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HALF (MAX_HALF)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_in    (i_pixel_in),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_median_value(o_median_value),
        .o_frame_done  (o_frame_done)
    );

    assign o_run_last = st.res_last;

endmodule
